// ===== design/ipl_upload_host_handshake_defines.svh =====
// ----------------------------------------------------------------------------
// IPL upload host handshake: assertion macros
// Concurrent assertion wrappers clocked on clk_i and held off during reset.
// In synthesis builds the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef IPL_UPLOAD_HOST_HANDSHAKE_DEFINES_SVH
`define IPL_UPLOAD_HOST_HANDSHAKE_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold on every clock edge outside reset
`define IPLH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define IPLH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IPLH_ASSERT(lbl, prop, msg)
`define IPLH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/iplh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPL upload host handshake package
// Codes, constants and types shared by the command decoder and the top level.
// ----------------------------------------------------------------------------
package iplh_pkg;

  // Command codes on the func field
  typedef enum logic [2:0] {
    FN_BEGIN = 3'd0,
    FN_DATA  = 3'd1,
    FN_CHUNK = 3'd2,
    FN_END   = 3'd3,
    FN_REPLY = 3'd4
  } func_e;

  // Bus operation codes on the result
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_DONE   = 2'd2,
    OP_REJECT = 2'd3
  } op_e;

  // Wait phase; code 3 is never entered and behaves as idle
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ECHO = 2'd1,
    PH_READ = 2'd2
  } phase_e;

  // Port numbers of the four-port mailbox
  localparam logic [1:0] PORT_HANDSHAKE = 2'd0;
  localparam logic [1:0] PORT_DATA      = 2'd1;
  localparam logic [1:0] PORT_ADDR_LO   = 2'd2;
  localparam logic [1:0] PORT_ADDR_HI   = 2'd3;

  localparam logic [7:0] BOOT_MAGIC = 8'hCC;
  localparam logic [7:0] FLAG_CHUNK = 8'h01;
  localparam logic [7:0] FLAG_EXEC  = 8'h00;
  localparam logic [7:0] ECHO_STEP  = 8'd2;

  // Most bus accesses one command can cause
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  // One bus access, without the last-of-run flag
  typedef struct packed {
    op_e        op;
    logic [1:0] port;
    logic [7:0] val;
  } res_t;

  // All accesses caused by one item
  typedef struct packed {
    logic [CntW-1:0]             cnt;
    res_t [MaxResults-1:0]       res;
  } run_t;

  // Handshake tracking state
  typedef struct packed {
    phase_e     phase;
    logic [7:0] echo;
    logic [7:0] counter;
  } state_t;

  function automatic res_t mk_res(op_e op, logic [1:0] port, logic [7:0] val);
    res_t r;
    r.op   = op;
    r.port = port;
    r.val  = val;
    return r;
  endfunction

endpackage

// ===== design/iplh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPL upload host handshake channels
// Command channel into the block and bus-access channel out of it.
// ----------------------------------------------------------------------------
interface iplh_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] target_address;
  logic [7:0]  payload_byte;
  logic [7:0]  reply_value;

  modport source (output valid, func, target_address, payload_byte, reply_value,
                  input ready);
  modport sink   (input valid, func, target_address, payload_byte, reply_value,
                  output ready);
endinterface

interface iplh_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] bus_op;
  logic [1:0] port_index;
  logic [7:0] write_value;
  logic       last_of_run;

  modport source (output valid, bus_op, port_index, write_value, last_of_run,
                  input ready);
  modport sink   (input valid, bus_op, port_index, write_value, last_of_run,
                  output ready);
endinterface

// ===== design/iplh_cmd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPL upload host handshake: command decoder
// Turns one item and the current handshake state into the list of bus
// accesses it causes and the next handshake state.
// ----------------------------------------------------------------------------
module iplh_cmd_decode
  import iplh_pkg::*;
(
  input  logic [2:0]  func_i,
  input  logic [15:0] target_address_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [7:0]  reply_value_i,
  input  state_t      state_i,
  output run_t        run_o,
  output state_t      state_o
);

  logic       waiting;
  logic [7:0] bumped;
  logic [7:0] next_echo;

  assign waiting   = (state_i.phase == PH_ECHO) || (state_i.phase == PH_READ);
  // Reply plus two, skipping zero
  assign bumped    = reply_value_i + ECHO_STEP;
  assign next_echo = (bumped == 8'd0) ? ECHO_STEP : bumped;

  always_comb begin
    run_o        = '0;
    run_o.cnt    = CntW'(1);
    run_o.res[0] = mk_res(OP_REJECT, PORT_HANDSHAKE, 8'd0);
    state_o      = state_i;

    if ((func_i <= FN_END) && waiting) begin
      // busy: reject, state untouched
    end else begin
      case (func_e'(func_i))
        FN_BEGIN: begin
          run_o.cnt    = CntW'(5);
          run_o.res[0] = mk_res(OP_WRITE, PORT_ADDR_LO, target_address_i[7:0]);
          run_o.res[1] = mk_res(OP_WRITE, PORT_ADDR_HI, target_address_i[15:8]);
          run_o.res[2] = mk_res(OP_WRITE, PORT_DATA, FLAG_CHUNK);
          run_o.res[3] = mk_res(OP_WRITE, PORT_HANDSHAKE, BOOT_MAGIC);
          run_o.res[4] = mk_res(OP_READ, PORT_HANDSHAKE, 8'd0);
          state_o.phase   = PH_ECHO;
          state_o.echo    = BOOT_MAGIC;
          state_o.counter = 8'd0;
        end
        FN_DATA: begin
          run_o.cnt    = CntW'(3);
          run_o.res[0] = mk_res(OP_WRITE, PORT_DATA, payload_byte_i);
          run_o.res[1] = mk_res(OP_WRITE, PORT_HANDSHAKE, state_i.counter);
          run_o.res[2] = mk_res(OP_READ, PORT_HANDSHAKE, 8'd0);
          state_o.phase   = PH_ECHO;
          state_o.echo    = state_i.counter;
          state_o.counter = state_i.counter + 8'd1;
        end
        FN_CHUNK, FN_END: begin
          run_o.cnt    = CntW'(4);
          run_o.res[0] = mk_res(OP_WRITE, PORT_ADDR_LO, target_address_i[7:0]);
          run_o.res[1] = mk_res(OP_WRITE, PORT_ADDR_HI, target_address_i[15:8]);
          run_o.res[2] = mk_res(OP_WRITE, PORT_DATA,
                                (func_i == FN_CHUNK) ? FLAG_CHUNK : FLAG_EXEC);
          run_o.res[3] = mk_res(OP_READ, PORT_HANDSHAKE, 8'd0);
          state_o.phase   = PH_READ;
          state_o.counter = 8'd0;
        end
        FN_REPLY: begin
          case (state_i.phase)
            PH_ECHO: begin
              if (reply_value_i == state_i.echo) begin
                run_o.res[0]  = mk_res(OP_DONE, PORT_HANDSHAKE, 8'd0);
                state_o.phase = PH_IDLE;
              end else begin
                // no echo yet: poll again
                run_o.res[0] = mk_res(OP_READ, PORT_HANDSHAKE, 8'd0);
              end
            end
            PH_READ: begin
              run_o.cnt    = CntW'(2);
              run_o.res[0] = mk_res(OP_WRITE, PORT_HANDSHAKE, next_echo);
              run_o.res[1] = mk_res(OP_READ, PORT_HANDSHAKE, 8'd0);
              state_o.phase = PH_ECHO;
              state_o.echo  = next_echo;
            end
            default: begin
              // unsolicited reply: reject
            end
          endcase
        end
        default: begin
          // undefined func: reject
        end
      endcase
    end
  end

endmodule

// ===== design/ipl_upload_host_handshake.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPL upload host handshake
// Host-side sequencer for the four-port boot-loader upload protocol.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries commands (begin transfer, data byte, begin chunk, end and
//   execute) and port 0 read replies. res_o carries the bus accesses the host
//   must make, one item per access, with last_of_run set on the final access
//   caused by a command.
//   The first access of a command is offered in the cycle after the
//   command is accepted. A command causes 1 to 5 accesses, offered one
//   access per cycle while res_o is ready, and a new command waits until
//   the last of them leaves; the single result port sets that limit.
//   The next command is taken in the same cycle the last access leaves.
//   While res_o is stalled the pending accesses hold in the result buffer
//   and cmd_i ready stays low.
//   Reset empties the buffer and returns the handshake to idle with the echo
//   and byte counter at zero.
// ----------------------------------------------------------------------------
`include "ipl_upload_host_handshake_defines.svh"

module ipl_upload_host_handshake
  import iplh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  iplh_cmd_if.sink    cmd_i,
  iplh_res_if.source  res_o
);

  state_t                state_q, state_d, state_next;
  run_t                  run;
  logic [CntW-1:0]       cnt_q, cnt_d;
  res_t [MaxResults-1:0] buf_q, buf_d;
  logic                  cmd_acc;
  logic                  res_take;

  // Decode the incoming item against the current state
  iplh_cmd_decode u_decode (
    .func_i           (cmd_i.func),
    .target_address_i (cmd_i.target_address),
    .payload_byte_i   (cmd_i.payload_byte),
    .reply_value_i    (cmd_i.reply_value),
    .state_i          (state_q),
    .run_o            (run),
    .state_o          (state_next)
  );

  // Handshakes
  assign res_take    = res_o.valid && res_o.ready;
  assign cmd_i.ready = (cnt_q == CntW'(0)) || ((cnt_q == CntW'(1)) && res_o.ready);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  // Result buffer: load on accept, shift down as accesses leave
  always_comb begin
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    state_d = state_q;
    if (cmd_acc) begin
      buf_d   = run.res;
      cnt_d   = run.cnt;
      state_d = state_next;
    end else if (res_take) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      state_q <= '{phase: PH_IDLE, echo: 8'd0, counter: 8'd0};
    end else begin
      cnt_q   <= cnt_d;
      state_q <= state_d;
    end
  end

  // Access payload
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // Output port
  assign res_o.valid       = (cnt_q != CntW'(0));
  assign res_o.bus_op      = buf_q[0].op;
  assign res_o.port_index  = buf_q[0].port;
  assign res_o.write_value = buf_q[0].val;
  assign res_o.last_of_run = (cnt_q == CntW'(1));

  // Checks
  `IPLH_ASSERT(a_cnt_range, cnt_q <= CntW'(MaxResults), "result count out of range")
  `IPLH_ASSERT_NEXT(a_drain_empty,
    res_take && res_o.last_of_run && !cmd_acc, cnt_q == CntW'(0),
    "buffer not empty after last access left")
  `IPLH_ASSERT_NEXT(a_begin_state,
    cmd_acc && (cmd_i.func == FN_BEGIN) && (state_q.phase == PH_IDLE),
    (state_q.phase == PH_ECHO) && (state_q.echo == BOOT_MAGIC) &&
    (state_q.counter == 8'd0) && (cnt_q == CntW'(5)),
    "begin transfer did not arm the echo wait")
  `IPLH_ASSERT_NEXT(a_busy_hold,
    cmd_acc && (cmd_i.func <= FN_END) &&
    ((state_q.phase == PH_ECHO) || (state_q.phase == PH_READ)),
    $stable(state_q) && (res_o.bus_op == OP_REJECT) && (cnt_q == CntW'(1)),
    "busy command changed state or was not rejected")

endmodule
